/* design/rebh_pkg.sv */
package rebh_pkg;

  // Input operation codes carried on in_tuser.
  typedef enum logic [1:0] {
    OP_PINS   = 2'd0,
    OP_BUTTON = 2'd1,
    OP_STATUS = 2'd2
  } op_t;

  // Turn direction codes, two's complement.
  localparam logic signed [1:0] TURN_NONE  = 2'sb00;
  localparam logic signed [1:0] TURN_RIGHT = 2'sb01;
  localparam logic signed [1:0] TURN_LEFT  = 2'sb11;

  // Quadrature codes with a meaning of their own.
  localparam logic [1:0] QUAD_ARMED = 2'd3;
  localparam logic [1:0] QUAD_LEFT_FROM  = 2'd2;
  localparam logic [1:0] QUAD_LEFT_TO    = 2'd1;
  localparam logic [1:0] QUAD_RIGHT_FROM = 2'd1;
  localparam logic [1:0] QUAD_RIGHT_TO   = 2'd2;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd20;

  localparam int unsigned DATA_W = 40;

  // Per-transaction step enables sent from the top level to the state units.
  typedef struct packed {
    logic quad_en;
    logic btn_en;
    logic rd_en;
  } ctl_t;

endpackage

/* design/rebh_quad.sv */
module rebh_quad (
  input  logic              clk,
  input  logic              rst_n,
  input  rebh_pkg::ctl_t    ctl,
  input  logic              pin_a,
  input  logic              pin_b,
  output logic signed [1:0] turn
);

  logic [1:0]        phase_r, phase_nxt;
  logic signed [1:0] turn_r, turn_nxt;
  logic [1:0]        code;

  assign code = {pin_a, pin_b};
  assign turn = turn_r;

  // Phase tracking and direction latch; a status read clears the latch.
  always_comb begin
    phase_nxt = phase_r;
    turn_nxt  = turn_r;
    if (ctl.rd_en) begin
      turn_nxt = rebh_pkg::TURN_NONE;
    end
    if (ctl.quad_en) begin
      if (code == rebh_pkg::QUAD_ARMED) begin
        phase_nxt = code;
      end else if (phase_r == rebh_pkg::QUAD_LEFT_FROM) begin
        if (code == rebh_pkg::QUAD_LEFT_TO) begin
          phase_nxt = 2'd0;
          turn_nxt  = rebh_pkg::TURN_LEFT;
        end
      end else if (phase_r == rebh_pkg::QUAD_RIGHT_FROM) begin
        if (code == rebh_pkg::QUAD_RIGHT_TO) begin
          phase_nxt = 2'd0;
          turn_nxt  = rebh_pkg::TURN_RIGHT;
        end
      end else begin
        phase_nxt = code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      turn_r  <= rebh_pkg::TURN_NONE;
    end else begin
      phase_r <= phase_nxt;
      turn_r  <= turn_nxt;
    end
  end

endmodule

/* design/rebh_button.sv */
module rebh_button (
  input  logic           clk,
  input  logic           rst_n,
  input  rebh_pkg::ctl_t ctl,
  input  logic           pin_button,
  input  logic [31:0]    now_ms,
  input  logic [15:0]    debounce_ms,
  output logic           press_event,
  output logic [31:0]    hold_ms
);

  logic        down_r, down_nxt;
  logic        reported_r, reported_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] release_r, release_nxt;
  logic [31:0] since_release;
  logic        step;

  assign step          = ctl.btn_en | ctl.rd_en;
  assign since_release = now_ms - release_r;

  // Press/release machine, then the status report on a read.
  always_comb begin
    down_nxt     = down_r;
    start_nxt    = start_r;
    release_nxt  = release_r;
    reported_nxt = reported_r;
    press_event  = 1'b0;
    hold_ms      = 32'd0;
    if (step) begin
      if (!down_r) begin
        if (!pin_button && (since_release > {16'd0, debounce_ms})) begin
          down_nxt  = 1'b1;
          start_nxt = now_ms;
        end
      end else if (pin_button) begin
        down_nxt    = 1'b0;
        release_nxt = now_ms;
      end
    end
    if (ctl.rd_en) begin
      if (down_nxt) begin
        // A press that starts on this read has held for zero time.
        hold_ms      = down_r ? (now_ms - start_r) : 32'd0;
        press_event  = !reported_r;
        reported_nxt = 1'b1;
      end else begin
        reported_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_r     <= 1'b0;
      reported_r <= 1'b0;
      start_r    <= 32'd0;
      release_r  <= 32'd0;
    end else begin
      down_r     <= down_nxt;
      reported_r <= reported_nxt;
      start_r    <= start_nxt;
      release_r  <= release_nxt;
    end
  end

endmodule

/* design/rotary_encoder_with_button_hold.sv */
// Channel  | Dir | Handshake         | Payload
// in_      | in  | in_tvalid/tready  | tuser: op; tdata: pin_a, pin_b, pin_button, now_ms
// out_     | out | out_tvalid/tready | tdata: turn, press_event, hold_ms
// cfg_     | in  | cfg_wr_en         | cfg_wr_data: debounce_ms
//
// One transaction per cycle unless a status read stalls behind a full result slot:
// a transaction sits in the input register while the state units update, and a
// status read then lands in the result register, which drives out_tvalid.
// Reset (rst_n low, synchronous) clears the valid flags and the state units and sets debounce_ms to 20.
// A stalled result holds up a following status read and the input behind it;
// pin and button transactions ahead of that read keep flowing past it.
module rotary_encoder_with_button_hold (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [0] pin_a, [1] pin_b, [2] pin_button, [34:3] now_ms, [39:35] zero
  input  logic [rebh_pkg::DATA_W-1:0]  in_tdata,
  // [1:0] op
  input  logic [1:0]                   in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [1:0] turn, [2] press_event, [34:3] hold_ms, [39:35] zero
  output logic [rebh_pkg::DATA_W-1:0]  out_tdata,
  input  logic                         cfg_wr_en,
  input  logic [15:0]                  cfg_wr_data
);

  logic              in_vld_r;
  rebh_pkg::op_t     in_op_r;
  logic              in_a_r, in_b_r, in_btn_r;
  logic [31:0]       in_now_r;
  logic [15:0]       debounce_r;
  logic              out_vld_r;
  logic [rebh_pkg::DATA_W-1:0] out_data_r;
  logic              proc_ok;
  logic              res_en;
  rebh_pkg::ctl_t    ctl;
  logic signed [1:0] turn;
  logic              press_event;
  logic [31:0]       hold_ms;

  // A held item proceeds unless it is a status read facing a full result slot that is stalled.
  assign proc_ok   = in_vld_r &&
                     ((in_op_r != rebh_pkg::OP_STATUS) || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || proc_ok;
  assign res_en    = ctl.rd_en;

  // Decode the held operation into step enables.
  always_comb begin
    ctl = '0;
    if (proc_ok) begin
      unique case (in_op_r)
        rebh_pkg::OP_PINS:   ctl.quad_en = 1'b1;
        rebh_pkg::OP_BUTTON: ctl.btn_en  = 1'b1;
        rebh_pkg::OP_STATUS: ctl.rd_en   = 1'b1;
        default:             ctl         = '0;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r  <= rebh_pkg::op_t'(in_tuser);
      in_a_r   <= in_tdata[0];
      in_b_r   <= in_tdata[1];
      in_btn_r <= in_tdata[2];
      in_now_r <= in_tdata[34:3];
    end
  end

  // Debounce configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= rebh_pkg::DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      debounce_r <= cfg_wr_data;
    end
  end

  rebh_quad u_quad (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .pin_a (in_a_r),
    .pin_b (in_b_r),
    .turn  (turn)
  );

  rebh_button u_button (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .pin_button  (in_btn_r),
    .now_ms      (in_now_r),
    .debounce_ms (debounce_r),
    .press_event (press_event),
    .hold_ms     (hold_ms)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_en) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_en) begin
      out_data_r <= {5'd0, hold_ms, press_event, turn};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // A result is only ever loaded from a status read.
  a_res_from_status: assert property (@(posedge clk) disable iff (!rst_n)
    res_en |-> (in_vld_r && in_op_r == rebh_pkg::OP_STATUS))
    else $error("result loaded without a status read");

  // The turn code is never the unused value -2.
  a_turn_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_data_r[1:0] != 2'b10))
    else $error("invalid turn code in result");

  // A status read behind a stalled result must back-pressure the input.
  a_status_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && in_op_r == rebh_pkg::OP_STATUS && out_vld_r && !out_tready)
      |-> (!in_tready && !res_en))
    else $error("status read overran a stalled result");

  // A stalled result holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> (out_vld_r && $stable(out_data_r)))
    else $error("stalled result changed");

endmodule

/* bench/rotary_encoder_with_button_hold_test.sv */
module rotary_encoder_with_button_hold_test;

  // Op code that the block must accept and ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Decoder phase after a latched turn.
  localparam logic [1:0] QUAD_IDLE = 2'd0;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 125;

  // One stimulus transaction, with an optional hand-typed status result.
  typedef struct packed {
    logic [1:0] op;
    logic a;
    logic b;
    logic btn;
    logic [31:0] now;
    logic typed;
    logic signed [1:0] turn;
    logic press;
    logic [31:0] hold;
  } row_t;

  typedef struct packed {
    logic signed [1:0] turn;
    logic press;
    logic [31:0] hold;
  } status_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [rebh_pkg::DATA_W-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [rebh_pkg::DATA_W-1:0] out_tdata;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;

  // Encoder state as the block should hold it.
  logic [1:0] dec_phase;
  logic signed [1:0] dec_turn;
  logic btn_down;
  logic [31:0] press_t0;
  logic [31:0] release_t;
  logic press_told;
  logic [15:0] hold_off;

  status_t status_due[$];
  status_t seen;
  row_t plan[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle = 0;
  int unsigned take_stall = 0;

  // Random stimulus state: encoder position, spin direction, button level, time.
  logic [1:0] quad_pos;
  logic [1:0] spin;
  logic lever;
  logic [31:0] clock_ms;

  rotary_encoder_with_button_hold DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("rotary_encoder_with_button_hold_test NOT OK");
      $finish;
    end
  end

  // The result side stalls at random.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= take_stall);
  end

  // Compare each result transaction with the oldest expected status.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (status_due.size() == 0) begin
        $error("unexpected status result %h", out_tdata);
        mismatches++;
      end else begin
        seen = status_due.pop_front();
        if (out_tdata[1:0] !== seen.turn) begin
          $error("turn: expected %0d, got %0d", seen.turn, $signed(out_tdata[1:0]));
          mismatches++;
        end
        if (out_tdata[2] !== seen.press) begin
          $error("press_event: expected %0d, got %0d", seen.press, out_tdata[2]);
          mismatches++;
        end
        if (out_tdata[34:3] !== seen.hold) begin
          $error("hold_ms: expected %0d, got %0d", seen.hold, out_tdata[34:3]);
          mismatches++;
        end
      end
    end
  end

  function automatic row_t plan_row(input logic [1:0] op, input logic a, input logic b,
                                    input logic btn, input logic [31:0] now,
                                    input logic typed, input logic signed [1:0] turn,
                                    input logic press, input logic [31:0] hold);
    row_t r;
    r.op = op;
    r.a = a;
    r.b = b;
    r.btn = btn;
    r.now = now;
    r.typed = typed;
    r.turn = turn;
    r.press = press;
    r.hold = hold;
    return r;
  endfunction

  // Button press/release machine with the debounce window.
  task automatic step_button(input logic pin, input logic [31:0] now);
    logic [31:0] since_release;
    since_release = now - release_t;
    if (!btn_down) begin
      if (!pin && since_release > {16'd0, hold_off}) begin
        btn_down = 1'b1;
        press_t0 = now;
      end
    end else if (pin) begin
      btn_down = 1'b0;
      release_t = now;
    end
  endtask

  // Advance the expected state by one accepted transaction.
  task automatic track_encoder(input row_t r);
    logic [1:0] code;
    status_t s;
    code = {r.a, r.b};
    case (r.op)
      rebh_pkg::OP_PINS: begin
        if (code == rebh_pkg::QUAD_ARMED) begin
          dec_phase = code;
        end else if (dec_phase == rebh_pkg::QUAD_LEFT_FROM) begin
          if (code == rebh_pkg::QUAD_LEFT_TO) begin
            dec_phase = QUAD_IDLE;
            dec_turn = rebh_pkg::TURN_LEFT;
          end
        end else if (dec_phase == rebh_pkg::QUAD_RIGHT_FROM) begin
          if (code == rebh_pkg::QUAD_RIGHT_TO) begin
            dec_phase = QUAD_IDLE;
            dec_turn = rebh_pkg::TURN_RIGHT;
          end
        end else begin
          dec_phase = code;
        end
      end
      rebh_pkg::OP_BUTTON: step_button(r.btn, r.now);
      rebh_pkg::OP_STATUS: begin
        s.turn = dec_turn;
        dec_turn = rebh_pkg::TURN_NONE;
        step_button(r.btn, r.now);
        if (btn_down) begin
          s.hold = r.now - press_t0;
          s.press = !press_told;
          press_told = 1'b1;
        end else begin
          s.hold = 32'd0;
          s.press = 1'b0;
          press_told = 1'b0;
        end
        if (r.typed) begin
          s.turn = r.turn;
          s.press = r.press;
          s.hold = r.hold;
        end
        status_due.push_back(s);
      end
      default: ;
    endcase
  endtask

  // Offer one transaction, with random gaps, and wait for it to be taken.
  task automatic send_item(input row_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.op;
    in_tdata <= {5'd0, r.now, r.btn, r.b, r.a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_encoder(r);
  endtask

  // Drop valid and let the block drain before touching the register.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (status_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_debounce(input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    hold_off = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly real rotation and press sequences, with some noise mixed in.
  task automatic random_item(output bit counted);
    row_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    r = '0;
    r.a = 1'($urandom_range(1));
    r.b = 1'($urandom_range(1));
    r.btn = 1'($urandom_range(1));
    case ($urandom_range(9))
      0, 1, 2, 3: clock_ms = clock_ms + $urandom_range(3);
      4, 5, 6: clock_ms = clock_ms + $urandom_range(200);
      7, 8: clock_ms = clock_ms + $urandom_range(70000);
      default: clock_ms = $urandom;
    endcase
    if (pick < 40) begin
      r.op = rebh_pkg::OP_PINS;
      if ($urandom_range(19) == 0) spin = -spin;
      if ($urandom_range(9) != 0) begin
        quad_pos = quad_pos + spin;
        {r.a, r.b} = quad_pos ^ (quad_pos >> 1);
      end
    end else if (pick < 70) begin
      r.op = rebh_pkg::OP_BUTTON;
      lever = ($urandom_range(4) == 0) ? 1'($urandom_range(1)) : !lever;
      // Aim a press right at the edge of the debounce window half the time.
      if (!lever && !btn_down && $urandom_range(1))
        clock_ms = release_t + {16'd0, hold_off} + $urandom_range(2);
      r.btn = lever;
    end else if (pick < 95) begin
      r.op = rebh_pkg::OP_STATUS;
      if ($urandom_range(7) == 0) lever = !lever;
      r.btn = lever;
    end else begin
      r.op = OP_UNUSED;
    end
    r.now = clock_ms;
    counted = (r.op != OP_UNUSED);
    send_item(r);
  endtask

  initial begin
    bit counted;
    int unsigned sent;
    logic [15:0] setting;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = rebh_pkg::OP_PINS;
    out_tready = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    dec_phase = QUAD_IDLE;
    dec_turn = rebh_pkg::TURN_NONE;
    btn_down = 1'b0;
    press_t0 = 32'd0;
    release_t = 32'd0;
    press_told = 1'b0;
    hold_off = rebh_pkg::DEBOUNCE_RESET;
    quad_pos = 2'd0;
    spin = 2'd1;
    lever = 1'b1;
    clock_ms = $urandom;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: both turn directions, the debounce edge, time wrap.
    plan.push_back(plan_row(rebh_pkg::OP_STATUS, 0, 0, 1, 32'd0, 1,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_PINS, 1, 1, 0, 32'd1, 0,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_PINS, 0, 1, 0, 32'd2, 0,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_PINS, 0, 0, 0, 32'd3, 0,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_PINS, 1, 0, 0, 32'd4, 0,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_STATUS, 0, 0, 1, 32'd5, 1,
                            rebh_pkg::TURN_RIGHT, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_PINS, 1, 1, 1, 32'd5, 0,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_PINS, 1, 0, 1, 32'd5, 0,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_PINS, 0, 0, 1, 32'd5, 0,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_PINS, 0, 1, 1, 32'd5, 0,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_STATUS, 1, 1, 1, 32'd6, 1,
                            rebh_pkg::TURN_LEFT, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_STATUS, 0, 0, 1, 32'd7, 1,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    // Press exactly at the debounce time is refused, one later is taken.
    plan.push_back(plan_row(rebh_pkg::OP_BUTTON, 0, 0, 0, 32'd20, 0,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_STATUS, 0, 0, 1, 32'd20, 1,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_BUTTON, 0, 0, 0, 32'd21, 0,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_STATUS, 0, 0, 0, 32'd21, 1,
                            rebh_pkg::TURN_NONE, 1, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_STATUS, 0, 0, 0, 32'd20, 1,
                            rebh_pkg::TURN_NONE, 0, 32'hFFFF_FFFF));
    plan.push_back(plan_row(rebh_pkg::OP_STATUS, 0, 0, 1, 32'd1000, 1,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_BUTTON, 0, 0, 0, 32'd1020, 0,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_STATUS, 0, 0, 0, 32'd1021, 1,
                            rebh_pkg::TURN_NONE, 1, 32'd0));
    // Release at the top of the time range, then press across the wrap.
    // The press was already reported by a read, and only a read while
    // released clears that, so this new press gives no press event.
    plan.push_back(plan_row(rebh_pkg::OP_BUTTON, 1, 1, 1, 32'hFFFF_FFFF, 0,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_BUTTON, 0, 0, 0, 32'h13, 0,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_BUTTON, 0, 0, 0, 32'h14, 0,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(OP_UNUSED, 1, 1, 1, 32'hFFFF_FFFF, 0,
                            rebh_pkg::TURN_NONE, 0, 32'd0));
    plan.push_back(plan_row(rebh_pkg::OP_STATUS, 1, 1, 0, 32'h78, 1,
                            rebh_pkg::TURN_NONE, 0, 32'd100));
    foreach (plan[i]) send_item(plan[i]);

    // Random part in phases, each with its own debounce setting and one of four idling patterns.
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: setting = 16'd0;
        1: setting = 16'hFFFF;
        2: setting = rebh_pkg::DEBOUNCE_RESET;
        3: setting = 16'($urandom_range(64, 1));
        4: setting = 16'($urandom_range(65535));
        default: setting = 16'($urandom_range(300));
      endcase
      write_debounce(setting);
      case (p % 4)
        0: begin send_idle = 0; take_stall = 0; end
        1: begin send_idle = 76; take_stall = 0; end
        2: begin send_idle = 0; take_stall = 76; end
        default: begin send_idle = 12; take_stall = 12; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        random_item(counted);
        if (counted) sent++;
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("rotary_encoder_with_button_hold_test OK");
    end else begin
      $display("rotary_encoder_with_button_hold_test NOT OK");
    end
    $finish;
  end

endmodule
